FILE: design/lrc_pkg.sv
// Shared types and constants for the leftmost/rightmost closure block.
package lrc_pkg;

    localparam int SYM_W = 5;
    localparam int CNT_W = 6;
    localparam int ROW_W = 32;

    typedef struct packed {
        logic             load;
        logic             mask;
        logic             close;
        logic             emit;
        logic             clear;
        logic [SYM_W-1:0] idx;
    } t_cmd;

endpackage

FILE: design/leftmost_rightmost_closure_core.sv
// Top level of the leftmost/rightmost relation closure block.
// Each input beat is one grammar production, taken when start is high and
// busy is low; it sets bit (head, first) in the leftmost matrix and bit
// (head, last) in the rightmost matrix, or is dropped if any of its symbols
// is at or above the active symbol count. Plain productions load back to back.
// A beat with i_last_production set raises busy, n being the active count:
// the block masks unused columns, runs the closure with one pivot row
// applied to every row at once for each of the n pivots, emits the n rows
// one per result beat, and clears both matrices.
// Result beats appear on consecutive cycles, each for exactly one cycle with
// o_valid high; the first one is registered from the first row emitted after
// the closure, and o_last_row marks the final row. The receiver
// cannot stall the block.
// A count of zero gives no result beats; busy stays high for one cycle while
// the matrices clear. Reset (synchronous, active low) clears both matrices
// and sets the symbol count to 32. The user writes the count through
// i_symbol_count_we only while idle; the block does not enforce this.
module leftmost_rightmost_closure_core
    import lrc_pkg::*;
#(
    parameter int MAX_SYMBOLS = 32
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_symbol_count_we,
    input  logic [CNT_W-1:0] i_symbol_count,
    input  logic             start,
    output logic             busy,
    input  logic [SYM_W-1:0] i_head_symbol,
    input  logic [SYM_W-1:0] i_first_body_symbol,
    input  logic [SYM_W-1:0] i_last_body_symbol,
    input  logic             i_last_production,
    output logic             o_valid,
    output logic [SYM_W-1:0] o_row_symbol,
    output logic [ROW_W-1:0] o_leftmost_row,
    output logic [ROW_W-1:0] o_rightmost_row,
    output logic             o_last_row
);

    localparam int DEPTH = (MAX_SYMBOLS < ROW_W) ? MAX_SYMBOLS : ROW_W;

    logic [CNT_W-1:0] r_symbol_count;
    logic [CNT_W-1:0] count_eff;
    logic             accept;
    t_cmd             cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= CNT_W'(32);
        end else if (i_symbol_count_we) begin
            r_symbol_count <= i_symbol_count;
        end
    end

    assign count_eff = (r_symbol_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_symbol_count;
    assign accept    = start && !busy;

    lrc_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_last_production (i_last_production),
        .i_count           (count_eff),
        .o_cmd             (cmd),
        .o_busy            (busy)
    );

    lrc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_count             (count_eff),
        .i_head_symbol       (i_head_symbol),
        .i_first_body_symbol (i_first_body_symbol),
        .i_last_body_symbol  (i_last_body_symbol),
        .o_valid             (o_valid),
        .o_row_symbol        (o_row_symbol),
        .o_leftmost_row      (o_leftmost_row),
        .o_rightmost_row     (o_rightmost_row),
        .o_last_row          (o_last_row)
    );

    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside of busy period");

    a_rows_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_row) |=> o_valid)
        else $error("gap in result beats");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_row) |=> !o_valid)
        else $error("result beat after last row");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_row_symbol} < count_eff))
        else $error("row symbol beyond active count");

    a_close_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_production) |=> busy)
        else $error("closing beat did not start work");

endmodule

FILE: design/lrc_ctrl.sv
// Controller state machine sequencing load, mask, closure, row output and clear.
module lrc_ctrl
    import lrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_last_production,
    input  logic [CNT_W-1:0] i_count,
    output t_cmd             o_cmd,
    output logic             o_busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MASK  = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [SYM_W-1:0] r_idx;
    logic [SYM_W-1:0] n_idx;
    logic             idx_last;

    assign idx_last = ({1'b0, r_idx} + CNT_W'(1)) == i_count;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        o_cmd.load  = i_accept;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_accept && i_last_production) begin
                    n_state = (i_count == '0) ? ST_CLEAR : ST_MASK;
                end
            end
            ST_MASK: begin
                o_cmd.mask = 1'b1;
                n_idx      = '0;
                n_state    = ST_CLOSE;
            end
            ST_CLOSE: begin
                o_cmd.close = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + SYM_W'(1);
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = ST_CLEAR;
                end else begin
                    n_idx = r_idx + SYM_W'(1);
                end
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: design/lrc_datapath.sv
// Datapath holding both relation matrices, the row-parallel closure update and the output beat.
module lrc_datapath
    import lrc_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [CNT_W-1:0] i_count,
    input  logic [SYM_W-1:0] i_head_symbol,
    input  logic [SYM_W-1:0] i_first_body_symbol,
    input  logic [SYM_W-1:0] i_last_body_symbol,
    output logic             o_valid,
    output logic [SYM_W-1:0] o_row_symbol,
    output logic [ROW_W-1:0] o_leftmost_row,
    output logic [ROW_W-1:0] o_rightmost_row,
    output logic             o_last_row
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ROW_W-1:0] r_lm [DEPTH];
    logic [ROW_W-1:0] r_rm [DEPTH];
    logic [ROW_W-1:0] n_lm [DEPTH];
    logic [ROW_W-1:0] n_rm [DEPTH];
    logic [ROW_W-1:0] col_mask;
    logic [ROW_W-1:0] piv_l;
    logic [ROW_W-1:0] piv_r;
    logic [ROW_W-1:0] first_bit;
    logic [ROW_W-1:0] last_bit;
    logic [IW-1:0]    row_sel;
    logic [SYM_W-1:0] col_sel;
    logic             load_ok;

    logic             r_valid;
    logic [SYM_W-1:0] r_row_symbol;
    logic [ROW_W-1:0] r_leftmost_row;
    logic [ROW_W-1:0] r_rightmost_row;
    logic             r_last_row;

    assign row_sel   = i_cmd.idx[IW-1:0];
    assign col_sel   = i_cmd.idx;
    assign piv_l     = r_lm[row_sel];
    assign piv_r     = r_rm[row_sel];
    assign first_bit = ROW_W'(1) << i_first_body_symbol;
    assign last_bit  = ROW_W'(1) << i_last_body_symbol;
    assign load_ok   = i_cmd.load
                       && ({1'b0, i_head_symbol} < i_count)
                       && ({1'b0, i_first_body_symbol} < i_count)
                       && ({1'b0, i_last_body_symbol} < i_count);

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            col_mask[j] = CNT_W'(j) < i_count;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_lm[i] = r_lm[i];
            n_rm[i] = r_rm[i];
            if (i_cmd.clear) begin
                n_lm[i] = '0;
                n_rm[i] = '0;
            end else if (i_cmd.mask) begin
                n_lm[i] = r_lm[i] & col_mask;
                n_rm[i] = r_rm[i] & col_mask;
            end else if (i_cmd.close) begin
                if (r_lm[i][col_sel]) begin
                    n_lm[i] = r_lm[i] | piv_l;
                end
                if (r_rm[i][col_sel]) begin
                    n_rm[i] = r_rm[i] | piv_r;
                end
            end else if (load_ok && (i_head_symbol == SYM_W'(i))) begin
                n_lm[i] = r_lm[i] | first_bit;
                n_rm[i] = r_rm[i] | last_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_lm[i] <= '0;
                r_rm[i] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                r_lm[i] <= n_lm[i];
                r_rm[i] <= n_rm[i];
            end
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_row_symbol    <= i_cmd.idx;
            r_leftmost_row  <= piv_l;
            r_rightmost_row <= piv_r;
            r_last_row      <= ({1'b0, i_cmd.idx} + CNT_W'(1)) == i_count;
        end
    end

    assign o_valid         = r_valid;
    assign o_row_symbol    = r_row_symbol;
    assign o_leftmost_row  = r_leftmost_row;
    assign o_rightmost_row = r_rightmost_row;
    assign o_last_row      = r_last_row;

endmodule
